FILE: src/ael_pkg.sv
// Shared types and constants for the arithmetic expression lexer.
// Used by the channel interfaces, the front end, the token queue and the top level.
package ael_pkg;

  localparam int unsigned MaxLenDefault    = 65535;
  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned ValWidth         = 32;
  localparam int unsigned PosWidth         = 16;

  typedef enum logic [3:0] {
    TOK_NUM,
    TOK_LPAREN,
    TOK_RPAREN,
    TOK_ADD,
    TOK_SUB,
    TOK_MUL,
    TOK_DIV,
    TOK_MOD,
    TOK_AND,
    TOK_OR,
    TOK_XOR,
    TOK_SHL,
    TOK_SHR,
    TOK_END,
    TOK_ERR
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_UNEXPECTED,
    ERR_UNCLOSED
  } err_kind_e;

  typedef struct packed {
    tok_kind_e             kind;
    logic [ValWidth-1:0]   value;
    err_kind_e             err_kind;
    logic [PosWidth-1:0]   err_pos;
    logic                  done;
  } tok_t;

  // Up to two tokens leave the front end per accepted character.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

endpackage

FILE: src/ael_ifs.sv
// Valid/ready channel interfaces for characters in and tokens out.
// Depends on ael_pkg for the field widths.
interface ael_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface ael_out_if;
  logic                                valid;
  logic                                ready;
  logic [3:0]                          kind;
  logic signed [ael_pkg::ValWidth-1:0] value;
  logic [1:0]                          error_kind;
  logic [ael_pkg::PosWidth-1:0]        error_position;
  logic                                string_done;

  modport source (output valid, output kind, output value, output error_kind,
                  output error_position, output string_done, input ready);
  modport sink (input valid, input kind, input value, input error_kind,
                input error_position, input string_done, output ready);
endinterface

FILE: src/ael_front.sv
// Front end of the lexer: takes one character request per cycle while room_i is high,
// classifies it and updates the scanner state. Depends on ael_pkg and ael_in_if.
module ael_front #(
  parameter int unsigned MaxLen    = ael_pkg::MaxLenDefault,
  parameter int unsigned ValueBits = ael_pkg::ValueBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ael_in_if.sink         in_i,
  input  logic           room_i,
  output ael_pkg::push_t push_o
);

  localparam int unsigned PosW = ael_pkg::PosWidth;
  localparam int unsigned ValW = ael_pkg::ValWidth;
  localparam logic [PosW-1:0] PosLimit =
    (MaxLen < 32'd65535) ? PosW'(MaxLen) : {PosW{1'b1}};
  localparam logic [15:0] DepthMax = 16'hFFFF;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;
  localparam logic [1:0] SHIFT_NONE = 2'd0;
  localparam logic [1:0] SHIFT_LT   = 2'd1;
  localparam logic [1:0] SHIFT_GT   = 2'd2;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;

  function automatic ael_pkg::tok_t op_tok(ael_pkg::tok_kind_e k);
    ael_pkg::tok_t t;
    t          = '0;
    t.kind     = k;
    t.err_kind = ael_pkg::ERR_NONE;
    return t;
  endfunction

  function automatic ael_pkg::tok_t err_tok(ael_pkg::err_kind_e ek, logic [PosW-1:0] pos);
    ael_pkg::tok_t t;
    t          = '0;
    t.kind     = ael_pkg::TOK_ERR;
    t.err_kind = ek;
    t.err_pos  = pos;
    t.done     = 1'b1;
    return t;
  endfunction

  logic                 expect_q, expect_d;
  logic [15:0]          depth_q, depth_d;
  logic                 num_act_q, num_act_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic [1:0]           sign_q, sign_d;
  logic [1:0]           shift_q, shift_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 disc_q, disc_d;

  logic                 accept;
  logic                 digit;
  logic [7:0]           ch_off;
  logic [ValueBits-1:0] dval;
  logic [ValueBits-1:0] acc_mac;
  logic [ValueBits-1:0] acc_signed;
  logic [ValW-1:0]      num_value;
  logic [PosW-1:0]      pos_prev;
  logic                 expect_now;
  logic                 raise_err;
  logic [PosW-1:0]      err_pos;
  logic                 num_push;
  logic                 oth_push;
  ael_pkg::tok_t        oth;
  ael_pkg::tok_t        num_tok;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid & room_i;

  assign digit      = (in_i.ch >= CH_ZERO) && (in_i.ch <= CH_NINE);
  assign ch_off     = in_i.ch - CH_ZERO;
  assign dval       = ValueBits'(ch_off[3:0]);
  // Times ten as two shifts and an add, then the new digit.
  assign acc_mac    = (acc_q << 3) + (acc_q << 1) + dval;
  assign acc_signed = neg_q ? (~acc_q + 1'b1) : acc_q;
  assign pos_prev   = (pos_q == '0) ? '0 : pos_q - 1'b1;

  if (ValueBits >= ValW) begin : g_val_wide
    assign num_value = acc_signed[ValW-1:0];
  end else begin : g_val_narrow
    assign num_value = {{(ValW - ValueBits){1'b0}}, acc_signed};
  end

  always_comb begin
    num_tok       = op_tok(ael_pkg::TOK_NUM);
    num_tok.value = num_value;
  end

  always_comb begin
    expect_d   = expect_q;
    depth_d    = depth_q;
    num_act_d  = num_act_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    sign_d     = sign_q;
    shift_d    = shift_q;
    pos_d      = pos_q;
    disc_d     = disc_q;
    expect_now = expect_q;
    raise_err  = 1'b0;
    err_pos    = pos_q;
    num_push   = 1'b0;
    oth_push   = 1'b0;
    oth        = op_tok(ael_pkg::TOK_END);

    if (accept && in_i.is_end) begin
      if (!disc_q) begin
        oth_push = 1'b1;
        if (sign_q != SIGN_NONE) begin
          oth = err_tok(ael_pkg::ERR_UNEXPECTED, pos_prev);
        end else if (shift_q != SHIFT_NONE) begin
          oth = err_tok(ael_pkg::ERR_UNEXPECTED, pos_q);
        end else begin
          num_push = num_act_q;
          if (depth_q != '0) begin
            oth = err_tok(ael_pkg::ERR_UNCLOSED, '0);
          end else begin
            oth      = op_tok(ael_pkg::TOK_END);
            oth.done = 1'b1;
          end
        end
      end
      // The end marker always returns the scanner to its idle state.
      expect_d  = 1'b1;
      depth_d   = '0;
      num_act_d = 1'b0;
      acc_d     = '0;
      neg_d     = 1'b0;
      sign_d    = SIGN_NONE;
      shift_d   = SHIFT_NONE;
      pos_d     = '0;
      disc_d    = 1'b0;
    end else if (accept) begin
      if (!disc_q) begin
        if (sign_q != SIGN_NONE) begin
          if (digit) begin
            num_act_d = 1'b1;
            neg_d     = (sign_q == SIGN_MINUS);
            acc_d     = dval;
            sign_d    = SIGN_NONE;
          end else begin
            raise_err = 1'b1;
            err_pos   = pos_prev;
          end
        end else if (shift_q != SHIFT_NONE) begin
          if ((shift_q == SHIFT_LT && in_i.ch == CH_LT) ||
              (shift_q == SHIFT_GT && in_i.ch == CH_GT)) begin
            oth_push = 1'b1;
            oth      = op_tok((shift_q == SHIFT_LT) ? ael_pkg::TOK_SHL : ael_pkg::TOK_SHR);
            shift_d  = SHIFT_NONE;
            expect_d = 1'b0;
          end else begin
            raise_err = 1'b1;
          end
        end else if (num_act_q && digit) begin
          acc_d = acc_mac;
        end else begin
          if (num_act_q) begin
            // A non-digit ends the running number; it goes out first.
            num_push   = 1'b1;
            num_act_d  = 1'b0;
            neg_d      = 1'b0;
            acc_d      = '0;
            expect_d   = 1'b0;
            expect_now = 1'b0;
          end
          if (in_i.ch == CH_SPACE) begin
            expect_d = expect_now;
          end else if (in_i.ch == CH_LPAREN) begin
            if (depth_q != DepthMax) begin
              depth_d = depth_q + 1'b1;
            end
            oth_push = 1'b1;
            oth      = op_tok(ael_pkg::TOK_LPAREN);
          end else if (in_i.ch == CH_RPAREN) begin
            if (depth_q == '0) begin
              raise_err = 1'b1;
            end else begin
              depth_d  = depth_q - 1'b1;
              oth_push = 1'b1;
              oth      = op_tok(ael_pkg::TOK_RPAREN);
            end
          end else if (expect_now) begin
            if (digit) begin
              num_act_d = 1'b1;
              neg_d     = 1'b0;
              acc_d     = dval;
            end else if (in_i.ch == CH_PLUS) begin
              sign_d = SIGN_PLUS;
            end else if (in_i.ch == CH_MINUS) begin
              sign_d = SIGN_MINUS;
            end else begin
              raise_err = 1'b1;
            end
          end else begin
            unique case (in_i.ch)
              CH_PLUS: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_ADD);
              end
              CH_MINUS: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_SUB);
              end
              CH_STAR: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_MUL);
              end
              CH_SLASH: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_DIV);
              end
              CH_PCT: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_MOD);
              end
              CH_AMP: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_AND);
              end
              CH_BAR: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_OR);
              end
              CH_CARET: begin
                oth_push = 1'b1;
                oth      = op_tok(ael_pkg::TOK_XOR);
              end
              CH_LT: shift_d = SHIFT_LT;
              CH_GT: shift_d = SHIFT_GT;
              default: raise_err = 1'b1;
            endcase
            if (oth_push) begin
              expect_d = 1'b1;
            end
          end
        end

        if (raise_err) begin
          oth_push  = 1'b1;
          oth       = err_tok(ael_pkg::ERR_UNEXPECTED, err_pos);
          disc_d    = 1'b1;
          num_act_d = 1'b0;
          sign_d    = SIGN_NONE;
          shift_d   = SHIFT_NONE;
        end
      end
      if (pos_q < PosLimit) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    push_o.cnt = {1'b0, num_push} + {1'b0, oth_push};
    push_o.t0  = num_push ? num_tok : oth;
    push_o.t1  = oth;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q  <= 1'b1;
      depth_q   <= '0;
      num_act_q <= 1'b0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      sign_q    <= SIGN_NONE;
      shift_q   <= SHIFT_NONE;
      pos_q     <= '0;
      disc_q    <= 1'b0;
    end else begin
      expect_q  <= expect_d;
      depth_q   <= depth_d;
      num_act_q <= num_act_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      sign_q    <= sign_d;
      shift_q   <= shift_d;
      pos_q     <= pos_d;
      disc_q    <= disc_d;
    end
  end

  // When two tokens leave together, the first is always the flushed number.
  a_pair_starts_with_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> (push_o.t0.kind == ael_pkg::TOK_NUM && !push_o.t0.done))
    else $error("two tokens pushed but the first is not a number");

  // An error raised by a character puts the scanner into discard mode.
  a_err_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.is_end && oth_push && oth.kind == ael_pkg::TOK_ERR) |=> disc_q)
    else $error("error token without entering discard mode");

endmodule

FILE: src/ael_queue.sv
// Token queue between the front end and the output channel; its head register
// drives the output port directly. Depends on ael_pkg and ael_out_if.
module ael_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ael_pkg::push_t push_i,
  output logic           room_o,
  ael_out_if.source      out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ael_pkg::tok_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;
  logic            pop;
  ael_pkg::tok_t   head;

  // Room for the worst case of two tokens from one character.
  assign room_o  = cnt_q <= CntW'(Depth - 2);
  assign wr_next = wr_q + 1'b1;
  assign pop     = out_o.valid && out_o.ready;
  assign head    = mem_q[rd_q];

  assign out_o.valid          = cnt_q != '0;
  assign out_o.kind           = head.kind;
  assign out_o.value          = signed'(head.value);
  assign out_o.error_kind     = head.err_kind;
  assign out_o.error_position = head.err_pos;
  assign out_o.string_done    = head.done;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.cnt);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.t0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, push_i.cnt} <= (CntW'(Depth) - cnt_q))
    else $error("token queue overflow");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == CntW'($past(cnt_q) + CntW'($past(push_i.cnt)) - CntW'($past(pop))))
    else $error("token count does not match pushes and pops");

endmodule

FILE: src/arith_expression_lexer.sv
// Top level of the arithmetic expression lexer.
// Instantiates ael_front and ael_queue; depends on ael_pkg and the channel interfaces.
//
// Characters enter one request per cycle and the front end classifies each one
// combinationally, so the block accepts a new character every cycle while the
// four-entry token queue has room for two tokens; a token is written into the
// queue as its character is accepted. Tokens leave at one per cycle while the
// output is ready, so a character that yields two tokens (a flushed number and
// an operator, parenthesis, error or end result) leaves as two transfers, and
// the output side sets the sustained rate when such pairs come back to back.
// Numbers accumulate by shift-and-add; there is no clearing pass after reset.
module arith_expression_lexer #(
  parameter int unsigned MaxLen    = ael_pkg::MaxLenDefault,
  parameter int unsigned ValueBits = ael_pkg::ValueBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ael_in_if.sink    in_i,
  ael_out_if.source out_o
);

  ael_pkg::push_t push;
  logic           room;

  ael_front #(
    .MaxLen   (MaxLen),
    .ValueBits(ValueBits)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .room_i(room),
    .push_o(push)
  );

  ael_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .room_o(room),
    .out_o (out_o)
  );

endmodule

FILE: tb/ael_token_checker.sv
`timescale 1ns / 100ps
// Token checker for the arithmetic expression lexer testbench: predicts the token
// stream from accepted characters and compares each accepted token field by field.
// Depends on ael_pkg and the channel interfaces in ael_ifs.
module ael_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ael_in_if           char_mon,
  ael_out_if          tok_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned tokens_owed_o,
  output int unsigned tokens_seen_o,
  output int unsigned error_tokens_o
);

  typedef enum logic [1:0] {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_e;
  typedef enum logic [1:0] {SHIFT_NONE, SHIFT_LEFT, SHIFT_RIGHT} shift_e;

  localparam logic [7:0] ChSpace   = " ";
  localparam logic [7:0] ChLparen  = "(";
  localparam logic [7:0] ChRparen  = ")";
  localparam logic [7:0] ChPlus    = "+";
  localparam logic [7:0] ChMinus   = "-";
  localparam logic [7:0] ChStar    = "*";
  localparam logic [7:0] ChSlash   = "/";
  localparam logic [7:0] ChPercent = "%";
  localparam logic [7:0] ChAmp     = "&";
  localparam logic [7:0] ChBar     = "|";
  localparam logic [7:0] ChCaret   = "^";
  localparam logic [7:0] ChLess    = "<";
  localparam logic [7:0] ChGreater = ">";
  localparam logic [7:0] ChZero    = "0";
  localparam logic [7:0] ChNine    = "9";
  // Both the character offset and the nesting depth stop at the 16-bit maximum.
  localparam logic [15:0] SatMax   = 16'hFFFF;

  logic                         expect_opnd;
  logic [15:0]                  depth;
  logic                         num_on;
  logic [ael_pkg::ValWidth-1:0] num_val;
  logic                         num_neg;
  sign_e                        pend_sign;
  shift_e                       pend_shift;
  logic [15:0]                  char_pos;
  logic                         discard;

  ael_pkg::tok_t tok_queue[$];

  task automatic clear_lexer();
    expect_opnd = 1'b1;
    depth       = '0;
    num_on      = 1'b0;
    num_val     = '0;
    num_neg     = 1'b0;
    pend_sign   = SIGN_NONE;
    pend_shift  = SHIFT_NONE;
    char_pos    = '0;
    discard     = 1'b0;
  endtask

  task automatic emit(ael_pkg::tok_kind_e k, logic [ael_pkg::ValWidth-1:0] v,
                      ael_pkg::err_kind_e ek, logic [ael_pkg::PosWidth-1:0] ep, logic d);
    ael_pkg::tok_t t;
    t = '{kind: k, value: v, err_kind: ek, err_pos: ep, done: d};
    tok_queue.push_back(t);
  endtask

  task automatic flush_number();
    emit(ael_pkg::TOK_NUM, num_neg ? -num_val : num_val, ael_pkg::ERR_NONE, '0, 1'b0);
    num_on      = 1'b0;
    num_neg     = 1'b0;
    num_val     = '0;
    expect_opnd = 1'b0;
  endtask

  // An error ends the string: everything up to the end marker is dropped.
  task automatic flag_bad_char(logic [15:0] p);
    emit(ael_pkg::TOK_ERR, '0, ael_pkg::ERR_UNEXPECTED, p, 1'b1);
    discard    = 1'b1;
    num_on     = 1'b0;
    pend_sign  = SIGN_NONE;
    pend_shift = SHIFT_NONE;
  endtask

  task automatic lex_char(logic [7:0] c);
    logic [15:0]        p;
    logic               digit;
    logic [7:0]         digit_val;
    ael_pkg::tok_kind_e k;
    p         = char_pos;
    digit     = (c >= ChZero) && (c <= ChNine);
    digit_val = c - ChZero;
    k         = ael_pkg::TOK_ERR;
    if (pend_sign != SIGN_NONE) begin
      // A sign must be followed directly by a digit; the error points at the sign.
      if (digit) begin
        num_on    = 1'b1;
        num_neg   = (pend_sign == SIGN_MINUS);
        num_val   = ael_pkg::ValWidth'(digit_val);
        pend_sign = SIGN_NONE;
      end else begin
        flag_bad_char((p == 0) ? '0 : p - 16'd1);
      end
    end else if (pend_shift != SHIFT_NONE) begin
      if ((pend_shift == SHIFT_LEFT && c == ChLess) ||
          (pend_shift == SHIFT_RIGHT && c == ChGreater)) begin
        emit((pend_shift == SHIFT_LEFT) ? ael_pkg::TOK_SHL : ael_pkg::TOK_SHR, '0,
             ael_pkg::ERR_NONE, '0, 1'b0);
        pend_shift  = SHIFT_NONE;
        expect_opnd = 1'b0;
      end else begin
        flag_bad_char(p);
      end
    end else if (num_on && digit) begin
      num_val = num_val * 10 + ael_pkg::ValWidth'(digit_val);
    end else begin
      if (num_on) flush_number();
      case (c)
        ChSpace: ;
        ChLparen: begin
          if (depth != SatMax) depth++;
          emit(ael_pkg::TOK_LPAREN, '0, ael_pkg::ERR_NONE, '0, 1'b0);
        end
        ChRparen: begin
          if (depth == 0) begin
            flag_bad_char(p);
          end else begin
            depth--;
            emit(ael_pkg::TOK_RPAREN, '0, ael_pkg::ERR_NONE, '0, 1'b0);
          end
        end
        default: begin
          if (expect_opnd) begin
            if (digit) begin
              num_on  = 1'b1;
              num_neg = 1'b0;
              num_val = ael_pkg::ValWidth'(digit_val);
            end else if (c == ChPlus) begin
              pend_sign = SIGN_PLUS;
            end else if (c == ChMinus) begin
              pend_sign = SIGN_MINUS;
            end else begin
              flag_bad_char(p);
            end
          end else begin
            case (c)
              ChPlus:    k = ael_pkg::TOK_ADD;
              ChMinus:   k = ael_pkg::TOK_SUB;
              ChStar:    k = ael_pkg::TOK_MUL;
              ChSlash:   k = ael_pkg::TOK_DIV;
              ChPercent: k = ael_pkg::TOK_MOD;
              ChAmp:     k = ael_pkg::TOK_AND;
              ChBar:     k = ael_pkg::TOK_OR;
              ChCaret:   k = ael_pkg::TOK_XOR;
              ChLess:    pend_shift = SHIFT_LEFT;
              ChGreater: pend_shift = SHIFT_RIGHT;
              default:   flag_bad_char(p);
            endcase
            if (k != ael_pkg::TOK_ERR) begin
              emit(k, '0, ael_pkg::ERR_NONE, '0, 1'b0);
              expect_opnd = 1'b1;
            end
          end
        end
      endcase
    end
  endtask

  task automatic lex_end_marker();
    if (!discard) begin
      if (pend_sign != SIGN_NONE) begin
        flag_bad_char((char_pos == 0) ? '0 : char_pos - 16'd1);
      end else if (pend_shift != SHIFT_NONE) begin
        flag_bad_char(char_pos);
      end else begin
        if (num_on) flush_number();
        if (depth != 0) emit(ael_pkg::TOK_ERR, '0, ael_pkg::ERR_UNCLOSED, '0, 1'b1);
        else            emit(ael_pkg::TOK_END, '0, ael_pkg::ERR_NONE, '0, 1'b1);
      end
    end
    clear_lexer();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: token %0d %s: got 0x%0h, predicted 0x%0h",
             $time, tokens_seen_o, what, got, want);
    mismatch_cnt_o++;
  endtask

  task automatic check_token();
    ael_pkg::tok_t want;
    if (tok_mon.kind == ael_pkg::TOK_ERR) error_tokens_o++;
    if (tok_queue.size() == 0) begin
      report_mismatch("arrived with none predicted, kind", tok_mon.kind, '0);
    end else begin
      want = tok_queue.pop_front();
      if (tok_mon.kind !== want.kind)
        report_mismatch("kind", tok_mon.kind, want.kind);
      if (tok_mon.value !== want.value)
        report_mismatch("value", tok_mon.value, want.value);
      if (tok_mon.error_kind !== want.err_kind)
        report_mismatch("error kind", tok_mon.error_kind, want.err_kind);
      if (tok_mon.error_position !== want.err_pos)
        report_mismatch("error position", tok_mon.error_position, want.err_pos);
      if (tok_mon.string_done !== want.done)
        report_mismatch("string done", tok_mon.string_done, want.done);
    end
    tokens_seen_o++;
  endtask

  // Tokens are checked before the request of the same edge is predicted; a token
  // can never come from a character accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lexer();
      tok_queue.delete();
    end else begin
      if (tok_mon.valid && tok_mon.ready) check_token();
      if (char_mon.valid && char_mon.ready) begin
        if (char_mon.is_end) begin
          lex_end_marker();
        end else begin
          if (!discard) lex_char(char_mon.ch);
          if (char_pos != SatMax) char_pos++;
        end
      end
      tokens_owed_o = tok_queue.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the arithmetic expression lexer testbench: clock, reset, character stimulus,
// token receiver and verdict. Depends on ael_ifs, arith_expression_lexer and ael_token_checker.
module testbench;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_ALTERNATE, STALL_RUNS} stall_e;

  localparam int unsigned ItemTarget  = 1550;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 16;
  localparam logic [7:0]  NulChar     = 8'h00;
  localparam logic [7:0]  TopChar     = 8'hFF;

  logic clk_i;
  logic rst_ni;

  ael_in_if  char_if ();
  ael_out_if tok_if ();

  int unsigned mismatch_cnt;
  int unsigned tokens_owed;
  int unsigned tokens_seen;
  int unsigned error_tokens;
  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned burst_left;
  bit          steady;
  int unsigned hold_asks;
  logic [7:0]  text_q[$];

  string op_text[10] = '{"+", "-", "*", "/", "%", "&", "|", "^", "<<", ">>"};
  string special_chars = "()+-<>*/%&|^ 09";

  arith_expression_lexer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (tok_if)
  );

  ael_token_checker u_token_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_mon       (char_if),
    .tok_mon        (tok_if),
    .mismatch_cnt_o (mismatch_cnt),
    .tokens_owed_o  (tokens_owed),
    .tokens_seen_o  (tokens_seen),
    .error_tokens_o (error_tokens)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d tokens still owed.", tokens_owed);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sends one request; unless steady, opens a new burst with a random gap when the last ran out.
  task automatic push_char(input logic [7:0] c, input logic e);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    char_if.valid  <= 1'b1;
    char_if.ch     <= c;
    char_if.is_end <= e;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_spaces();
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) add_text(" ");
  endtask

  function automatic logic [7:0] pick_special();
    return special_chars[$urandom_range(0, special_chars.len() - 1)];
  endfunction

  // Mostly short operands, some long enough to wrap around 32 bits.
  task automatic add_number();
    int unsigned pick;
    int unsigned ndig;
    pick = $urandom_range(0, 19);
    if (pick < 3) add_text(($urandom_range(0, 1) != 0) ? "+" : "-");
    pick = $urandom_range(0, 19);
    ndig = (pick < 14) ? $urandom_range(1, 3) :
           (pick < 19) ? $urandom_range(4, 10) : $urandom_range(11, 20);
    repeat (ndig) text_q.push_back("0" + 8'($urandom_range(0, 9)));
  endtask

  task automatic build_expr();
    int unsigned terms;
    int unsigned open;
    terms = $urandom_range(1, 8);
    open  = 0;
    for (int t = 0; t < terms; t++) begin
      while (open < 6 && $urandom_range(0, 3) == 0) begin
        add_text("(");
        open++;
        add_spaces();
      end
      add_number();
      add_spaces();
      while (open != 0 && $urandom_range(0, 2) == 0) begin
        add_text(")");
        open--;
        add_spaces();
      end
      if (t + 1 < terms) begin
        add_text(op_text[$urandom_range(0, 9)]);
        add_spaces();
      end
    end
    // Now and then the string ends with parentheses still open.
    if ($urandom_range(0, 7) != 0) repeat (open) add_text(")");
  endtask

  task automatic mangle_text();
    int unsigned idx;
    idx = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0: text_q[idx] = 8'($urandom_range(0, 255));
      1: text_q.insert(idx, pick_special());
      2: text_q = text_q[0:idx];
      default: text_q[idx] = pick_special();
    endcase
  endtask

  task automatic add_noise();
    repeat ($urandom_range(0, 10))
      text_q.push_back(($urandom_range(0, 1) != 0) ? pick_special()
                                                   : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_string();
    steady = ($urandom_range(0, 7) == 0);
    foreach (text_q[i]) push_char(text_q[i], 1'b0);
    push_char(8'($urandom_range(0, 255)), 1'b1);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic send_direct(input string s);
    add_text(s);
    send_string();
  endtask

  initial begin
    stall_e      mode;
    int unsigned run;
    int unsigned holds_done;
    holds_done   = 0;
    tok_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holds_done != hold_asks) begin
        // Long hold-off: the sender keeps offering until the block backs up.
        tok_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        mode = stall_e'($urandom_range(0, 3));
        run  = $urandom_range(8, 64);
        for (int k = 0; k < run; k++) begin
          case (mode)
            STALL_NONE:      tok_if.ready <= 1'b1;
            STALL_COIN:      tok_if.ready <= 1'($urandom_range(0, 1));
            STALL_ALTERNATE: tok_if.ready <= k[0];
            default:         tok_if.ready <= (k % 8) >= 3;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    bit          held_twice;
    rst_ni         = 1'b0;
    char_if.valid  = 1'b0;
    char_if.ch     = '0;
    char_if.is_end = 1'b0;
    held_twice     = 1'b0;
    hold_asks      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unmatched close, sign at the end, lone shift after a number, unclosed
    // parenthesis, NUL and top character codes, most negative operand.
    send_direct(")");
    send_direct("-");
    send_direct("1<2");
    send_direct("(");
    text_q.push_back(NulChar);
    send_string();
    text_q.push_back(TopChar);
    send_string();
    send_direct("-2147483648");

    hold_asks++;
    while (items_sent < ItemTarget) begin
      if (!held_twice && items_sent > ItemTarget / 2) begin
        hold_asks++;
        held_twice = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        build_expr();
      end else if (pick < 9) begin
        build_expr();
        mangle_text();
      end else begin
        add_noise();
      end
      send_string();
    end

    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tokens_owed != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d requests over %0d strings, with two long output stalls.",
             items_sent, strings_sent);
    $display("Checked %0d tokens, %0d of them error results.", tokens_seen, error_tokens);
    if (mismatch_cnt == 0 && tokens_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
